/* design/assert_macros.svh */
// assertion macros used by the converter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define PFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pfb_pkg.sv */
// shared types, constants and format helpers of the bgra converter
package pfb_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned MAX_PIXELS    = 16777216;
  localparam int unsigned MAX_BYTES     = 67108864;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [4:0] FMT_COPY_OPAQUE   = 5'd4;
  localparam logic [4:0] FMT_COPY_PREMUL   = 5'd5;
  localparam logic [4:0] FMT_COPY_STRAIGHT = 5'd6;
  localparam logic [4:0] FMT_SWAP_OPAQUE   = 5'd16;
  localparam logic [4:0] FMT_SWAP_PREMUL   = 5'd17;
  localparam logic [4:0] FMT_SWAP_STRAIGHT = 5'd18;
  localparam logic [4:0] FMT_SWAP_PACKED   = 5'd13;
  localparam logic [4:0] FMT_COPY_PACKED   = 5'd29;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_STRIDE = 2'd2,
    CFG_FORMAT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CFG  = 2'd1,
    ST_PAST_END = 2'd2
  } status_e;

  typedef struct packed {
    logic swap;
    logic force_alpha;
    logic premul;
  } fmt_class_t;

  typedef struct packed {
    status_e    status;
    fmt_class_t cls;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic       row_end;
    logic       image_end;
  } pfb_item_t;

  function automatic logic [2:0] fmt_bpp(input logic [4:0] fmt);
    logic [2:0] bpp;
    case (fmt) inside
      FMT_COPY_OPAQUE, FMT_COPY_PREMUL, FMT_COPY_STRAIGHT,
      FMT_SWAP_OPAQUE, FMT_SWAP_PREMUL, FMT_SWAP_STRAIGHT: bpp = 3'd4;
      FMT_SWAP_PACKED, FMT_COPY_PACKED:                    bpp = 3'd3;
      default:                                             bpp = 3'd0;
    endcase
    return bpp;
  endfunction

  function automatic fmt_class_t fmt_class(input logic [4:0] fmt);
    fmt_class_t c;
    c = '0;
    case (fmt) inside
      FMT_SWAP_PACKED, FMT_SWAP_OPAQUE, FMT_SWAP_PREMUL, FMT_SWAP_STRAIGHT: c.swap = 1'b1;
      default: c.swap = 1'b0;
    endcase
    case (fmt) inside
      FMT_COPY_OPAQUE, FMT_SWAP_OPAQUE, FMT_SWAP_PACKED, FMT_COPY_PACKED: c.force_alpha = 1'b1;
      default: c.force_alpha = 1'b0;
    endcase
    case (fmt) inside
      FMT_COPY_PREMUL, FMT_SWAP_PREMUL: c.premul = 1'b1;
      default: c.premul = 1'b0;
    endcase
    return c;
  endfunction

endpackage

/* design/pfb_front.sv */
// front end: configuration registers, byte assembly and classification
module pfb_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            accept_i,
  input  logic [7:0]                      data_byte_i,
  output logic                            push_o,
  output pfb_pkg::pfb_item_t              item_o
);
  import pfb_pkg::*;

  logic [12:0] width_q, width_d;
  logic [12:0] height_q, height_d;
  logic [15:0] stride_q, stride_d;
  logic [4:0]  fmt_q, fmt_d;
  logic        cfg_ok_q, cfg_ok_d;
  logic [15:0] row_bytes_q, row_bytes_d;
  logic [2:0]  bpp_q, bpp_d;

  logic [1:0]  phase_q, phase_d;
  logic [23:0] held_q, held_d;
  logic [15:0] rbc_q, rbc_d;
  logic [12:0] rc_q, rc_d;
  logic        done_q, done_d;

  logic [25:0] wh;
  logic [27:0] wh4;
  logic [28:0] sh;
  logic        in_row;
  logic        complete;
  logic [16:0] rbc_inc;
  logic [12:0] rc_inc;

  // configuration registers and derived validity
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    stride_d = stride_q;
    fmt_d    = fmt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_d  = cfg_data_i[12:0];
        CFG_HEIGHT: height_d = cfg_data_i[12:0];
        CFG_STRIDE: stride_d = cfg_data_i[15:0];
        CFG_FORMAT: fmt_d    = cfg_data_i[4:0];
        default:    width_d  = width_q;
      endcase
    end
    bpp_d       = fmt_bpp(fmt_d);
    row_bytes_d = 16'(width_d) * 16'(bpp_d);
    wh          = 26'(width_d) * 26'(height_d);
    wh4         = {wh, 2'b00};
    sh          = 29'(stride_d) * 29'(height_d);
    cfg_ok_d    = (width_d != '0) && (height_d != '0)
                  && (32'(width_d) <= MAX_DIMENSION) && (32'(height_d) <= MAX_DIMENSION)
                  && (32'(wh) <= MAX_PIXELS) && (bpp_d != '0)
                  && (stride_d >= row_bytes_d)
                  && (32'(sh) <= MAX_BYTES) && (32'(wh4) <= MAX_BYTES);
  end

  // stream position and pixel assembly
  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    rbc_d    = rbc_q;
    rc_d     = rc_q;
    done_d   = done_q;
    push_o   = 1'b0;
    item_o   = '0;
    in_row   = rbc_q < row_bytes_q;
    complete = in_row && ((3'({1'b0, phase_q}) + 3'd1) >= bpp_q);
    rbc_inc  = 17'(rbc_q) + 17'd1;
    rc_inc   = rc_q + 13'd1;
    if (cfg_we_i) begin
      phase_d = '0;
      held_d  = '0;
      rbc_d   = '0;
      rc_d    = '0;
      done_d  = 1'b0;
    end else if (accept_i) begin
      if (!cfg_ok_q) begin
        push_o        = 1'b1;
        item_o.status = ST_BAD_CFG;
      end else if (done_q) begin
        push_o        = 1'b1;
        item_o.status = ST_PAST_END;
      end else begin
        if (complete) begin
          push_o           = 1'b1;
          item_o.status    = ST_OK;
          item_o.cls       = fmt_class(fmt_q);
          item_o.b0        = held_q[7:0];
          item_o.b1        = held_q[15:8];
          item_o.b2        = (bpp_q == 3'd3) ? data_byte_i : held_q[23:16];
          item_o.b3        = (bpp_q == 3'd3) ? 8'd0 : data_byte_i;
          item_o.row_end   = rbc_inc == 17'(row_bytes_q);
          item_o.image_end = (rbc_inc == 17'(row_bytes_q))
                             && (14'(rc_q) + 14'd1 == 14'(height_q));
          phase_d          = '0;
          held_d           = '0;
        end else if (in_row) begin
          held_d  = held_q | (24'(data_byte_i) << {phase_q, 3'b000});
          phase_d = phase_q + 2'd1;
        end
        if (rbc_inc >= 17'(stride_q)) begin
          rbc_d = '0;
          rc_d  = rc_inc;
          if (rc_inc >= height_q) begin
            done_d = 1'b1;
          end
        end else begin
          rbc_d = rbc_inc[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= '0;
      height_q    <= '0;
      stride_q    <= '0;
      fmt_q       <= '0;
      cfg_ok_q    <= 1'b0;
      row_bytes_q <= '0;
      bpp_q       <= '0;
      phase_q     <= '0;
      held_q      <= '0;
      rbc_q       <= '0;
      rc_q        <= '0;
      done_q      <= 1'b0;
    end else begin
      width_q     <= width_d;
      height_q    <= height_d;
      stride_q    <= stride_d;
      fmt_q       <= fmt_d;
      cfg_ok_q    <= cfg_ok_d;
      row_bytes_q <= row_bytes_d;
      bpp_q       <= bpp_d;
      phase_q     <= phase_d;
      held_q      <= held_d;
      rbc_q       <= rbc_d;
      rc_q        <= rc_d;
      done_q      <= done_d;
    end
  end

endmodule

/* design/pfb_queue.sv */
// short fifo between the front end and the back end
module pfb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pfb_pkg::pfb_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output pfb_pkg::pfb_item_t head_o
);
  import pfb_pkg::*;

  pfb_item_t             mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;

  assign full_o  = count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* design/pfb_back.sv */
// back end: byte order, alpha, premultiply and output register
module pfb_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  pfb_pkg::pfb_item_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_blue_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_alpha_o,
  output logic               row_end_o,
  output logic               image_end_o,
  output logic [1:0]         status_o
);
  import pfb_pkg::*;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] x;
    logic [16:0] q;
    x = 17'(p) + 17'd127;
    q = (x + 17'd1 + (x >> 8)) >> 8;
    return q[7:0];
  endfunction

  logic        s1_valid_q;
  logic [15:0] s1_blue_q, s1_green_q, s1_red_q;
  logic [7:0]  s1_alpha_q;
  logic        s1_premul_q;
  logic        s1_row_end_q, s1_image_end_q;
  status_e     s1_status_q;

  logic        out_valid_q;
  logic [7:0]  out_blue_q, out_green_q, out_red_q, out_alpha_q;
  logic        out_row_end_q, out_image_end_q;
  status_e     out_status_q;

  logic        out_ready;
  logic        s1_ready;
  logic [7:0]  blue, green, red, alpha;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign pop_o     = head_valid_i && s1_ready;

  always_comb begin
    blue  = head_i.cls.swap ? head_i.b2 : head_i.b0;
    green = head_i.b1;
    red   = head_i.cls.swap ? head_i.b0 : head_i.b2;
    alpha = head_i.cls.force_alpha ? ALPHA_OPAQUE : head_i.b3;
  end

  // stage one: products
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_blue_q      <= head_i.cls.premul ? 16'(blue) * 16'(alpha) : 16'(blue);
      s1_green_q     <= head_i.cls.premul ? 16'(green) * 16'(alpha) : 16'(green);
      s1_red_q       <= head_i.cls.premul ? 16'(red) * 16'(alpha) : 16'(red);
      s1_alpha_q     <= alpha;
      s1_premul_q    <= head_i.cls.premul;
      s1_row_end_q   <= head_i.row_end;
      s1_image_end_q <= head_i.image_end;
      s1_status_q    <= head_i.status;
    end
  end

  // stage two: rounding divide and output register
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_ready) begin
      out_blue_q      <= s1_premul_q ? div255(s1_blue_q) : s1_blue_q[7:0];
      out_green_q     <= s1_premul_q ? div255(s1_green_q) : s1_green_q[7:0];
      out_red_q       <= s1_premul_q ? div255(s1_red_q) : s1_red_q[7:0];
      out_alpha_q     <= s1_alpha_q;
      out_row_end_q   <= s1_row_end_q;
      out_image_end_q <= s1_image_end_q;
      out_status_q    <= s1_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= head_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_blue_o  = out_blue_q;
  assign out_green_o = out_green_q;
  assign out_red_o   = out_red_q;
  assign out_alpha_o = out_alpha_q;
  assign row_end_o   = out_row_end_q;
  assign image_end_o = out_image_end_q;
  assign status_o    = out_status_q;

endmodule

/* design/pixel_format_to_bgra_premultiplied_core.sv */
// top level of the raw image to premultiplied bgra8 converter
//
//   channel   signals                                        direction
//   config    cfg_we_i, cfg_index_i, cfg_data_i              write only
//   input     in_valid_i, in_stall_o, data_byte_i            one byte per transaction
//   output    out_valid_o, out_stall_i, pixel fields, status zero or one per byte
//
// one source byte per cycle is taken while in_stall_o is low; the queue is written on the edge that takes the byte
// from there a pixel passes the queue, the product register and the output register to reach the output
// a 4-entry queue sits between byte assembly and the two-stage back end
// out_stall_i backs up the back end, then the queue, then in_stall_o rises
// reset clears all control state; no clearing pass is needed
`include "assert_macros.svh"

module pixel_format_to_bgra_premultiplied_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      data_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_blue_o,
  output logic [7:0]                      out_green_o,
  output logic [7:0]                      out_red_o,
  output logic [7:0]                      out_alpha_o,
  output logic                            row_end_o,
  output logic                            image_end_o,
  output logic [1:0]                      status_o
);
  import pfb_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  pfb_item_t push_item;
  pfb_item_t head_item;
  logic      accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  pfb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (q_push),
    .item_o      (push_item)
  );

  pfb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  pfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o),
    .out_alpha_o  (out_alpha_o),
    .row_end_o    (row_end_o),
    .image_end_o  (image_end_o),
    .status_o     (status_o)
  );

  `PFB_ASSERT_IMP(a_err_fields_zero, clk_i, rst_ni,
    out_valid_o && (status_o != ST_OK),
    (out_blue_o == '0) && (out_green_o == '0) && (out_red_o == '0)
      && (out_alpha_o == '0) && !row_end_o && !image_end_o,
    "error transaction carries nonzero pixel fields")

  `PFB_ASSERT_IMP(a_image_end_row_end, clk_i, rst_ni,
    out_valid_o && image_end_o, row_end_o,
    "image end without row end")

  `PFB_ASSERT_NXT(a_pop_fills_stage, clk_i, rst_ni,
    q_pop && !q_push && q_full, !q_full,
    "queue still full after a pop without push")

endmodule

/* bench/bgra_pixel_checker.sv */
// predicts the bgra pixels of the converter and checks every output transaction
module bgra_pixel_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [7:0]                     out_blue_i,
  input  logic [7:0]                     out_green_i,
  input  logic [7:0]                     out_red_i,
  input  logic [7:0]                     out_alpha_i,
  input  logic                           row_end_i,
  input  logic                           image_end_i,
  input  logic [1:0]                     status_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import pfb_pkg::*;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    status_e    status;
  } bgra_pixel_t;

  bgra_pixel_t expected_pixels[$];
  int          fail_count;

  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [15:0] stride_r;
  logic [4:0]  format_r;

  logic [1:0]  byte_phase;
  logic [23:0] held_bytes;
  logic [15:0] row_pos;
  logic [12:0] rows_done;
  logic        image_done;

  assign fail_count_o = fail_count;

  function automatic int unsigned pixel_bytes(input logic [4:0] fmt);
    case (fmt) inside
      FMT_COPY_OPAQUE, FMT_COPY_PREMUL, FMT_COPY_STRAIGHT,
      FMT_SWAP_OPAQUE, FMT_SWAP_PREMUL, FMT_SWAP_STRAIGHT: return 4;
      FMT_SWAP_PACKED, FMT_COPY_PACKED:                    return 3;
      default:                                             return 0;
    endcase
  endfunction

  function automatic bit geometry_ok();
    longint unsigned w, h, s, bpp;
    w   = width_r;
    h   = height_r;
    s   = stride_r;
    bpp = pixel_bytes(format_r);
    if (w == 0 || h == 0) return 1'b0;
    if (w > MAX_DIMENSION || h > MAX_DIMENSION) return 1'b0;
    if (w * h > MAX_PIXELS) return 1'b0;
    if (bpp == 0) return 1'b0;
    if (s < w * bpp) return 1'b0;
    if (s * h > MAX_BYTES) return 1'b0;
    if (w * 4 * h > MAX_BYTES) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] premultiply(input logic [7:0] v, input logic [7:0] a);
    int unsigned p;
    p = int'(v) * int'(a) + 127;
    return 8'(p / 255);
  endfunction

  task automatic clear_frame();
    byte_phase = '0;
    held_bytes = '0;
    row_pos    = '0;
    rows_done  = '0;
    image_done = 1'b0;
  endtask

  task automatic convert_byte(input logic [7:0] b, output bit emit, output bgra_pixel_t px);
    int unsigned bpp, row_bytes;
    logic [7:0]  b0, b1, b2, b3;
    bit          pixel_done, last_row, last_image, swap;
    px         = '0;
    emit       = 1'b1;
    pixel_done = 1'b0;
    last_row   = 1'b0;
    last_image = 1'b0;
    b0 = '0;
    b1 = '0;
    b2 = '0;
    b3 = '0;
    if (!geometry_ok()) begin
      px.status = ST_BAD_CFG;
      return;
    end
    if (image_done) begin
      px.status = ST_PAST_END;
      return;
    end
    bpp       = pixel_bytes(format_r);
    row_bytes = width_r * bpp;
    if (row_pos < row_bytes) begin
      if (byte_phase + 1 >= bpp) begin
        b0 = held_bytes[7:0];
        b1 = held_bytes[15:8];
        if (bpp == 3) begin
          b2 = b;
        end else begin
          b2 = held_bytes[23:16];
          b3 = b;
        end
        pixel_done = 1'b1;
        last_row   = (row_pos + 1 == row_bytes);
        last_image = last_row && (rows_done + 1 == height_r);
        byte_phase = '0;
        held_bytes = '0;
      end else begin
        held_bytes = held_bytes | (24'(b) << (8 * byte_phase));
        byte_phase = byte_phase + 2'd1;
      end
    end
    row_pos = row_pos + 16'd1;
    if (row_pos >= stride_r) begin
      row_pos   = '0;
      rows_done = rows_done + 13'd1;
      if (rows_done >= height_r) image_done = 1'b1;
    end
    emit = pixel_done;
    if (!pixel_done) return;
    swap = (format_r == FMT_SWAP_PACKED || format_r == FMT_SWAP_OPAQUE ||
            format_r == FMT_SWAP_PREMUL || format_r == FMT_SWAP_STRAIGHT);
    px.blue  = swap ? b2 : b0;
    px.green = b1;
    px.red   = swap ? b0 : b2;
    if (format_r == FMT_COPY_OPAQUE || format_r == FMT_SWAP_OPAQUE ||
        format_r == FMT_SWAP_PACKED || format_r == FMT_COPY_PACKED) begin
      px.alpha = ALPHA_OPAQUE;
    end else begin
      px.alpha = b3;
    end
    if (format_r == FMT_COPY_PREMUL || format_r == FMT_SWAP_PREMUL) begin
      px.blue  = premultiply(px.blue, px.alpha);
      px.green = premultiply(px.green, px.alpha);
      px.red   = premultiply(px.red, px.alpha);
    end
    px.row_end   = last_row;
    px.image_end = last_image;
    px.status    = ST_OK;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_pixel();
    bgra_pixel_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: output transaction with none expected, actual status %0d blue %0d",
               $time, status_i, out_blue_i);
      fail_count++;
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("status", want.status, status_i);
    compare_field("blue", want.blue, out_blue_i);
    compare_field("green", want.green, out_green_i);
    compare_field("red", want.red, out_red_i);
    compare_field("alpha", want.alpha, out_alpha_i);
    compare_field("row_end", want.row_end, row_end_i);
    compare_field("image_end", want.image_end, image_end_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit          emit;
    bgra_pixel_t px;
    if (!rst_ni) begin
      width_r    = '0;
      height_r   = '0;
      stride_r   = '0;
      format_r   = '0;
      fail_count = 0;
      expected_pixels.delete();
      clear_frame();
    end else begin
      if (out_valid_i && !out_stall_i) check_pixel();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  width_r  = cfg_data_i[12:0];
          CFG_HEIGHT: height_r = cfg_data_i[12:0];
          CFG_STRIDE: stride_r = cfg_data_i[15:0];
          default:    format_r = cfg_data_i[4:0];
        endcase
        clear_frame();
      end else if (in_valid_i && !in_stall_i) begin
        convert_byte(data_byte_i, emit, px);
        if (emit) expected_pixels.push_back(px);
      end
    end
    pending_o = expected_pixels.size();
  end

endmodule

/* bench/testbench.sv */
// stimulus and verdict for the raw image to premultiplied bgra converter
module testbench;
  import pfb_pkg::*;

  localparam int HOLD_CYCLES      = 80;
  localparam int IDLE_LIMIT       = 4000;
  localparam int RANDOM_PER_PHASE = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [7:0]            out_blue_o;
  logic [7:0]            out_green_o;
  logic [7:0]            out_red_o;
  logic [7:0]            out_alpha_o;
  logic                  row_end_o;
  logic                  image_end_o;
  logic [1:0]            status_o;

  int fail_count;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_req    = 0;
  int sent_items  = 0;
  int idle_cycles = 0;

  logic [4:0] valid_formats [8] = '{FMT_COPY_OPAQUE, FMT_COPY_PREMUL, FMT_COPY_STRAIGHT,
                                    FMT_SWAP_OPAQUE, FMT_SWAP_PREMUL, FMT_SWAP_STRAIGHT,
                                    FMT_SWAP_PACKED, FMT_COPY_PACKED};
  int pace_idle  [4] = '{0, 78, 0, 9};
  int pace_stall [4] = '{0, 0, 78, 9};

  pixel_format_to_bgra_premultiplied_core dut (.*);

  bgra_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blue_i   (out_blue_o),
    .out_green_i  (out_green_o),
    .out_red_i    (out_red_o),
    .out_alpha_i  (out_alpha_o),
    .row_end_i    (row_end_o),
    .image_end_i  (image_end_o),
    .status_i     (status_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(negedge clk_i);
    $display("[pixel_format_to_bgra_premultiplied_core] ERROR");
    $finish;
  end

  function automatic logic [7:0] random_byte();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [4:0] unknown_format();
    logic [4:0] f;
    bit         hit;
    do begin
      f   = 5'($urandom_range(31));
      hit = 1'b0;
      foreach (valid_formats[i]) if (valid_formats[i] == f) hit = 1'b1;
    end while (hit);
    return f;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i  = 1'b1;
    data_byte_i = b;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_byte(random_byte());
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic load_image(input int unsigned w, input int unsigned h,
                            input int unsigned s, input logic [4:0] fmt);
    wait_drained();
    cfg_write(CFG_WIDTH, 16'(w));
    cfg_write(CFG_HEIGHT, 16'(h));
    cfg_write(CFG_STRIDE, 16'(s));
    cfg_write(CFG_FORMAT, 16'(fmt));
  endtask

  task automatic set_pace(input int idle, input int stall, input bit hold);
    @(posedge clk_i);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_req++;
    @(negedge clk_i);
  endtask

  task automatic random_image();
    int unsigned kind, k, w, h, s, bpp, total;
    logic [4:0]  fmt;
    kind = $urandom_range(99);
    k    = $urandom_range(7);
    fmt  = valid_formats[k];
    bpp  = (k < 6) ? 4 : 3;
    w    = $urandom_range(1, 6);
    h    = $urandom_range(1, 4);
    s    = w * bpp + $urandom_range(0, 3);
    if (kind < 8) begin
      case (kind % 4)
        0:       fmt = unknown_format();
        1:       s = $urandom_range(0, w * bpp - 1);
        2:       w = 0;
        default: h = 0;
      endcase
      load_image(w, h, s, fmt);
      send_random($urandom_range(1, 4));
    end else begin
      total = s * h;
      if (kind >= 92) total = $urandom_range(1, total - 1);
      else if (kind < 25) total += $urandom_range(1, 3);
      load_image(w, h, s, fmt);
      send_random(total);
    end
  endtask

  initial begin
    int start;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers still at reset
    send_byte(8'h5A);

    // single three-byte pixel with padding, then a byte past the end
    load_image(1, 1, 4, FMT_SWAP_PACKED);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h11);
    send_byte(8'h3C);

    // premultiply with half and zero alpha over two rows
    load_image(1, 2, 4, FMT_COPY_PREMUL);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);

    // invalid setups
    load_image(2, 1, 8, unknown_format());
    send_byte(8'hAA);
    load_image('hF001, 1, 16, FMT_COPY_OPAQUE);
    send_byte(8'h55);
    load_image(2, 1, 7, FMT_COPY_OPAQUE);
    send_byte(8'h01);
    load_image(1, MAX_DIMENSION, 16'hFFFF, FMT_COPY_OPAQUE);
    send_byte(8'hFE);

    // largest dimensions that are still valid
    load_image(MAX_DIMENSION, 1, 4 * MAX_DIMENSION, FMT_SWAP_OPAQUE);
    send_random(4);
    load_image(1, MAX_DIMENSION, 4, FMT_COPY_PACKED);
    send_random(3);

    // long receiver hold-off while bytes keep coming
    load_image(4, 3, 16, FMT_COPY_STRAIGHT);
    set_pace(0, 0, 1'b1);
    send_random(48);

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      set_pace(pace_idle[p], pace_stall[p], 1'b0);
      start = sent_items;
      while (sent_items - start < RANDOM_PER_PHASE) random_image();
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[pixel_format_to_bgra_premultiplied_core] OK");
    end else begin
      $display("[pixel_format_to_bgra_premultiplied_core] ERROR");
    end
    $finish;
  end

endmodule
